>>> design/qyd_pkg.sv
`timescale 1ns / 1ps

package qyd_pkg;

   // Field and product widths
   localparam int QUAT_W = 16;
   localparam int PROD_W = 2 * QUAT_W;
   localparam int HEAD_W = 16;

   // Angle accumulator: signed degrees, 16 fraction bits
   localparam int ANG_FRAC  = 16;
   localparam int ANG_W     = 27;
   localparam int RND_SHIFT = ANG_FRAC - 7;
   localparam int RES_W     = ANG_W - RND_SHIFT;

   localparam int ATAN_TAB_LEN = 24;

   localparam logic signed [ANG_W-1:0] DEG_180 = 27'sd11796480;
   localparam logic signed [ANG_W-1:0] DEG_360 = 27'sd23592960;
   localparam logic [ANG_W-1:0]        RND_ADD = 27'd256;
   localparam logic [RES_W-1:0]        HEAD_WRAP = 18'd46080;

   // atan(2^-i) in degrees, Q.16, rounded to nearest
   localparam logic signed [ANG_W-1:0] ATAN_DEG_TAB [ATAN_TAB_LEN] = '{
      27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
      27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
      27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
      27'sd917,     27'sd458,     27'sd229,    27'sd115,
      27'sd57,      27'sd29,      27'sd14,     27'sd7,
      27'sd4,       27'sd2,       27'sd1,      27'sd0
   };

endpackage

>>> design/qyd_req_if.sv
`timescale 1ns / 1ps

interface qyd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [qyd_pkg::QUAT_W-1:0]   quat_x;
   logic signed [qyd_pkg::QUAT_W-1:0]   quat_y;
   logic signed [qyd_pkg::QUAT_W-1:0]   quat_z;
   logic signed [qyd_pkg::QUAT_W-1:0]   quat_w;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

>>> design/qyd_rsp_if.sv
`timescale 1ns / 1ps

interface qyd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [qyd_pkg::HEAD_W-1:0]    heading_deg;

   modport source (output valid, heading_deg, input ready);
   modport sink (input valid, heading_deg, output ready);
endinterface

>>> design/qyd_terms.sv
`timescale 1ns / 1ps

// Three stages: products, sin/cos terms, quadrant pre-rotation.
module qyd_terms #(
   parameter int FRAC_BITS = 14,
   parameter int TERM_W    = 34,
   parameter int CW        = 37
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [qyd_pkg::QUAT_W-1:0] quat_x,
   input  logic signed [qyd_pkg::QUAT_W-1:0] quat_y,
   input  logic signed [qyd_pkg::QUAT_W-1:0] quat_z,
   input  logic signed [qyd_pkg::QUAT_W-1:0] quat_w,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [CW-1:0]              out_x,
   output logic signed [CW-1:0]              out_y,
   output logic signed [qyd_pkg::ANG_W-1:0]  out_ang,
   output logic                              out_zero
);

   localparam logic signed [TERM_W-1:0] ONE_TERM =
      {{(TERM_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic r1, r2, r3;

   logic signed [qyd_pkg::PROD_W-1:0] p_wz_ff, p_xy_ff, p_yy_ff, p_zz_ff;
   logic signed [qyd_pkg::PROD_W-1:0] p_wz_in, p_xy_in, p_yy_in, p_zz_in;
   logic signed [TERM_W-1:0]          s_ff, s_in, c_ff, c_in;
   logic                              zero2_ff, zero2_in;
   logic signed [CW-1:0]              x_ff, x_in, y_ff, y_in;
   logic signed [qyd_pkg::ANG_W-1:0]  ang_ff, ang_in;
   logic                              zero3_ff;

   assign r3 = !v3_ff || out_ready;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   assign v1_in = r1 ? in_valid : v1_ff;
   assign v2_in = r2 ? v1_ff : v2_ff;
   assign v3_in = r3 ? v2_ff : v3_ff;

   always_comb begin
      p_wz_in = quat_w * quat_z;
      p_xy_in = quat_x * quat_y;
      p_yy_in = quat_y * quat_y;
      p_zz_in = quat_z * quat_z;
   end

   always_comb begin
      s_in = (TERM_W'(p_wz_ff) + TERM_W'(p_xy_ff)) <<< 1;
      c_in = ONE_TERM - ((TERM_W'(p_yy_ff) + TERM_W'(p_zz_ff)) <<< 1);
      zero2_in = (s_in == '0) && (c_in == '0);
   end

   // Cosine term negative: turn the vector by 180 degrees first
   always_comb begin
      x_in   = CW'(c_ff);
      y_in   = CW'(s_ff);
      ang_in = '0;
      if (c_ff[TERM_W-1]) begin
         x_in   = -CW'(c_ff);
         y_in   = -CW'(s_ff);
         ang_in = s_ff[TERM_W-1] ? -qyd_pkg::DEG_180 : qyd_pkg::DEG_180;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && r1) begin
         p_wz_ff <= p_wz_in;
         p_xy_ff <= p_xy_in;
         p_yy_ff <= p_yy_in;
         p_zz_ff <= p_zz_in;
      end
      if (v1_ff && r2) begin
         s_ff     <= s_in;
         c_ff     <= c_in;
         zero2_ff <= zero2_in;
      end
      if (v2_ff && r3) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         ang_ff   <= ang_in;
         zero3_ff <= zero2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_ang   = ang_ff;
   assign out_zero  = zero3_ff;

endmodule

>>> design/qyd_cordic_stage.sv
`timescale 1ns / 1ps

// One vectoring micro-rotation, registered.
module qyd_cordic_stage #(
   parameter int CW   = 37,
   parameter int STEP = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [CW-1:0]              in_x,
   input  logic signed [CW-1:0]              in_y,
   input  logic signed [qyd_pkg::ANG_W-1:0]  in_ang,
   input  logic                              in_zero,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [CW-1:0]              out_x,
   output logic signed [CW-1:0]              out_y,
   output logic signed [qyd_pkg::ANG_W-1:0]  out_ang,
   output logic                              out_zero
);

   localparam logic signed [qyd_pkg::ANG_W-1:0] ATAN_STEP = qyd_pkg::ATAN_DEG_TAB[STEP];

   logic                             valid_ff, valid_in, rdy;
   logic signed [CW-1:0]             x_ff, x_in, y_ff, y_in;
   logic signed [qyd_pkg::ANG_W-1:0] ang_ff, ang_in;
   logic                             zero_ff;
   logic signed [CW-1:0]             dx, dy;

   assign rdy      = !valid_ff || out_ready;
   assign in_ready = rdy;
   assign valid_in = rdy ? in_valid : valid_ff;

   always_comb begin
      dx = in_y >>> STEP;
      dy = in_x >>> STEP;
      if (!in_y[CW-1]) begin
         x_in   = in_x + dx;
         y_in   = in_y - dy;
         ang_in = in_ang + ATAN_STEP;
      end else begin
         x_in   = in_x - dx;
         y_in   = in_y + dy;
         ang_in = in_ang - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         ang_ff  <= ang_in;
         zero_ff <= in_zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_ang   = ang_ff;
   assign out_zero  = zero_ff;

endmodule

>>> design/qyd_finish.sv
`timescale 1ns / 1ps

// Wrap to [0, 360), then round to Q9.7 into the output register.
module qyd_finish (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [qyd_pkg::ANG_W-1:0]  in_ang,
   input  logic                              in_zero,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [qyd_pkg::HEAD_W-1:0]        heading_deg
);

   logic v1_ff, v1_in, v2_ff, v2_in, r1, r2;
   logic [qyd_pkg::ANG_W-2:0]        pos_ff, pos_in;
   logic                             zero1_ff;
   logic signed [qyd_pkg::ANG_W-1:0] ang_adj;
   logic [qyd_pkg::ANG_W-1:0]        rnd_sum;
   logic [qyd_pkg::RES_W-1:0]        res_raw, res_wrap;
   logic [qyd_pkg::HEAD_W-1:0]       heading_ff, heading_in;

   assign r2 = !v2_ff || out_ready;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;
   assign v1_in = r1 ? in_valid : v1_ff;
   assign v2_in = r2 ? v1_ff : v2_ff;

   always_comb begin
      ang_adj = in_ang;
      if (in_ang[qyd_pkg::ANG_W-1]) begin
         ang_adj = in_ang + qyd_pkg::DEG_360;
      end
      pos_in = ang_adj[qyd_pkg::ANG_W-1] ? '0 : ang_adj[qyd_pkg::ANG_W-2:0];
   end

   // Round half up; a rounded 360.0 wraps to 0
   always_comb begin
      rnd_sum  = {1'b0, pos_ff} + qyd_pkg::RND_ADD;
      res_raw  = rnd_sum[qyd_pkg::ANG_W-1:qyd_pkg::RND_SHIFT];
      res_wrap = res_raw;
      if (res_raw >= qyd_pkg::HEAD_WRAP) begin
         res_wrap = res_raw - qyd_pkg::HEAD_WRAP;
      end
      if (res_wrap >= qyd_pkg::HEAD_WRAP) begin
         res_wrap = '0;
      end
      heading_in = zero1_ff ? '0 : res_wrap[qyd_pkg::HEAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && r1) begin
         pos_ff   <= pos_in;
         zero1_ff <= in_zero;
      end
      if (v1_ff && r2) begin
         heading_ff <= heading_in;
      end
   end

   assign out_valid   = v2_ff;
   assign heading_deg = heading_ff;

   zero_vector_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && r2 && zero1_ff) |=> (heading_ff == '0))
      else $error("zero vector did not give a zero heading");

endmodule

>>> design/quaternion_yaw_degrees_core.sv
`timescale 1ns / 1ps
// Pipeline from an accepted req beat to its rsp beat: 3 term/pre-rotation stages,
// one stage per CORDIC micro-rotation, 2 finish stages.
// Throughput: one beat per cycle; each stage holds its beat only while downstream stalls.
// Bubbles collapse: a stage takes a new beat whenever it is empty or draining.
// Reset clears the stage valid bits only; no other state.
module quaternion_yaw_degrees_core #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 14
) (
   input  logic      clock,
   input  logic      reset,
   qyd_req_if.sink   req_port,
   qyd_rsp_if.source rsp_port
);

   localparam int TERM_W = (2 * FRAC_BITS + 2 > 34) ? 2 * FRAC_BITS + 2 : 34;
   localparam int CW     = TERM_W + 3;

   logic [CORDIC_STEPS:0]            cv, cr;
   logic signed [CW-1:0]             cx [CORDIC_STEPS+1];
   logic signed [CW-1:0]             cy [CORDIC_STEPS+1];
   logic signed [qyd_pkg::ANG_W-1:0] ca [CORDIC_STEPS+1];
   logic [CORDIC_STEPS:0]            cz;

   qyd_terms #(
      .FRAC_BITS (FRAC_BITS),
      .TERM_W    (TERM_W),
      .CW        (CW)
   ) u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .quat_x    (req_port.quat_x),
      .quat_y    (req_port.quat_y),
      .quat_z    (req_port.quat_z),
      .quat_w    (req_port.quat_w),
      .out_valid (cv[0]),
      .out_ready (cr[0]),
      .out_x     (cx[0]),
      .out_y     (cy[0]),
      .out_ang   (ca[0]),
      .out_zero  (cz[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      qyd_cordic_stage #(
         .CW   (CW),
         .STEP (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .in_ready  (cr[i]),
         .in_x      (cx[i]),
         .in_y      (cy[i]),
         .in_ang    (ca[i]),
         .in_zero   (cz[i]),
         .out_valid (cv[i+1]),
         .out_ready (cr[i+1]),
         .out_x     (cx[i+1]),
         .out_y     (cy[i+1]),
         .out_ang   (ca[i+1]),
         .out_zero  (cz[i+1])
      );
   end

   qyd_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cv[CORDIC_STEPS]),
      .in_ready    (cr[CORDIC_STEPS]),
      .in_ang      (ca[CORDIC_STEPS]),
      .in_zero     (cz[CORDIC_STEPS]),
      .out_valid   (rsp_port.valid),
      .out_ready   (rsp_port.ready),
      .heading_deg (rsp_port.heading_deg)
   );

   heading_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.heading_deg < 16'd46080))
      else $error("heading out of range");

   empty_output_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_port.valid |-> req_port.ready)
      else $error("input stalled with empty output stage");

   draining_output_takes_input: assert property (@(posedge clock) disable iff (reset)
      rsp_port.ready |-> req_port.ready)
      else $error("input stalled while output drains");

endmodule
